// ----- hdl/stw_pkg.sv -----
package stw_pkg;

   // Number formats
   localparam int FRAC_BITS   = 16;
   localparam int IN_W        = 32;
   localparam int OUT_BITS    = 16;
   // |2*source + period| and the remainder datapath
   localparam int AW          = IN_W + 2;
   localparam int DEN_W       = IN_W + 1;
   localparam int MUL_W       = DEN_W + FRAC_BITS;
   localparam int DW          = MUL_W + 1;
   localparam int MOD_STEPS   = AW;
   localparam int RATIO_STEPS = OUT_BITS;

   localparam logic signed [IN_W-1:0] PEAK_ONE = IN_W'(1) << FRAC_BITS;
   localparam logic [OUT_BITS:0]      WAVE_ONE = (OUT_BITS+1)'(1) << OUT_BITS;

   typedef struct packed {
      logic signed [IN_W-1:0] source_value;
      logic signed [IN_W-1:0] wave_period;
      logic signed [IN_W-1:0] peak_position;
   } req_beat_type;

   typedef struct packed {
      logic [OUT_BITS:0] wave_value;
      logic              period_error;
   } rsp_beat_type;

   typedef enum logic [1:0] {
      MODE_RISE,
      MODE_FALL,
      MODE_TRI
   } peak_mode_type;

   // Side info that travels with an item down the cell rows
   typedef struct packed {
      logic                 period_error;
      logic                 neg;
      logic                 sat;
      peak_mode_type        mode;
      logic [FRAC_BITS-1:0] peak;
   } stw_ctx_type;

   // One slot of a restoring-division row
   typedef struct packed {
      logic                valid;
      logic [DW-1:0]       rem;
      logic [DW-1:0]       div;
      logic [DW-1:0]       dvd;
      logic [OUT_BITS-1:0] quo;
      stw_ctx_type         ctx;
   } div_slot_type;

endpackage

// ----- hdl/skewed_triangle_wave_core.sv -----
// Skewed triangle wave. Each beat carries a source value, a period and a peak
// position in signed Q16.16; the result is the triangle value in unsigned
// Q0.16 (65536 is one), truncated, with period_error set and the value zero
// when the period is zero. One beat is taken every clock cycle; the whole
// pipeline stalls together while a result waits on rsp_ready. A 34-cell row
// forms the phase remainder, a floor-fix and a scaling register follow, a
// 16-cell row forms the output fraction, then the output register.
module skewed_triangle_wave_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  stw_pkg::req_beat_type req_beat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output stw_pkg::rsp_beat_type rsp_beat
);
   import stw_pkg::*;

   logic en;

   logic signed [IN_W+2:0] a_full;
   logic signed [IN_W+2:0] a_adj;
   logic signed [IN_W:0]   p_abs;
   logic [AW-1:0]          a_abs;
   logic [DEN_W-1:0]       d_in;
   peak_mode_type          mode_in;

   div_slot_type mod_slot   [0:MOD_STEPS];
   div_slot_type ratio_slot [0:RATIO_STEPS];

   logic [DEN_W-1:0]   rem_w;
   logic               s1_valid_ff;
   logic [DEN_W-1:0]   s1_num_ff, s1_num_in;
   logic [DEN_W-1:0]   s1_den_ff;
   stw_ctx_type        s1_ctx_ff;

   logic               s2_valid_ff;
   logic [DEN_W-1:0]   s2_num_ff, s2_den_ff;
   logic [MUL_W-1:0]   s2_rise_ff, s2_rise_in;
   logic [MUL_W-1:0]   s2_fall_ff, s2_fall_in;
   stw_ctx_type        s2_ctx_ff;

   logic [DEN_W-1:0]   s2_left;
   logic [MUL_W-1:0]   n_rise, n_fall, n_sel, m_sel;
   logic               sat;

   logic               rsp_valid_ff;
   rsp_beat_type       rsp_beat_ff, rsp_beat_in;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // Phase as a rational number: (2v + p) / (2p), sign moved to the numerator
   always_comb begin
      a_full = {req_beat.source_value[IN_W-1], req_beat.source_value[IN_W-1],
                req_beat.source_value, 1'b0}
             + {{3{req_beat.wave_period[IN_W-1]}}, req_beat.wave_period};
      a_adj  = req_beat.wave_period[IN_W-1] ? -a_full : a_full;
      a_abs  = a_adj[IN_W+2] ? AW'(-a_adj) : AW'(a_adj);
      p_abs  = req_beat.wave_period[IN_W-1]
               ? -{req_beat.wave_period[IN_W-1], req_beat.wave_period}
               : {req_beat.wave_period[IN_W-1], req_beat.wave_period};
      d_in   = {p_abs[IN_W-1:0], 1'b0};
      if (req_beat.peak_position >= PEAK_ONE) begin
         mode_in = MODE_RISE;
      end else if (req_beat.peak_position <= $signed(IN_W'(0))) begin
         mode_in = MODE_FALL;
      end else begin
         mode_in = MODE_TRI;
      end
      mod_slot[0].valid = req_valid;
      mod_slot[0].rem   = '0;
      mod_slot[0].div   = DW'(d_in);
      mod_slot[0].dvd   = DW'(a_abs) << (DW - AW);
      mod_slot[0].quo   = '0;
      mod_slot[0].ctx.period_error = (req_beat.wave_period == '0);
      mod_slot[0].ctx.neg  = a_adj[IN_W+2];
      mod_slot[0].ctx.sat  = 1'b0;
      mod_slot[0].ctx.mode = mode_in;
      mod_slot[0].ctx.peak = req_beat.peak_position[FRAC_BITS-1:0];
   end

   // Remainder row
   for (genvar i = 0; i < MOD_STEPS; i++) begin : g_mod
      stw_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .prev_slot (mod_slot[i]),
         .next_slot (mod_slot[i+1])
      );
   end

   // Floor fix for a negative numerator
   always_comb begin
      rem_w     = mod_slot[MOD_STEPS].rem[DEN_W-1:0];
      s1_num_in = (mod_slot[MOD_STEPS].ctx.neg && rem_w != '0)
                  ? mod_slot[MOD_STEPS].div[DEN_W-1:0] - rem_w : rem_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= mod_slot[MOD_STEPS].valid;
         s1_num_ff   <= s1_num_in;
         s1_den_ff   <= mod_slot[MOD_STEPS].div[DEN_W-1:0];
         s1_ctx_ff   <= mod_slot[MOD_STEPS].ctx;
      end
   end

   // Scale the denominator by the peak and by one minus the peak
   always_comb begin
      s2_rise_in = MUL_W'(s1_den_ff) * MUL_W'(s1_ctx_ff.peak);
      s2_fall_in = MUL_W'(s1_den_ff) * MUL_W'(FRAC_BITS'(~s1_ctx_ff.peak + 1'b1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
         s2_num_ff   <= s1_num_ff;
         s2_den_ff   <= s1_den_ff;
         s2_rise_ff  <= s2_rise_in;
         s2_fall_ff  <= s2_fall_in;
         s2_ctx_ff   <= s1_ctx_ff;
      end
   end

   // Pick the side of the triangle and set up the output division
   always_comb begin
      s2_left = s2_den_ff - s2_num_ff;
      n_rise  = MUL_W'(s2_num_ff) << FRAC_BITS;
      n_fall  = MUL_W'(s2_left) << FRAC_BITS;
      unique case (s2_ctx_ff.mode)
         MODE_RISE: begin
            n_sel = MUL_W'(s2_num_ff);
            m_sel = MUL_W'(s2_den_ff);
         end
         MODE_FALL: begin
            n_sel = MUL_W'(s2_left);
            m_sel = MUL_W'(s2_den_ff);
         end
         default: begin
            if (n_rise <= s2_rise_ff) begin
               n_sel = n_rise;
               m_sel = s2_rise_ff;
            end else begin
               n_sel = n_fall;
               m_sel = s2_fall_ff;
            end
         end
      endcase
      sat = (n_sel >= m_sel);
      ratio_slot[0].valid   = s2_valid_ff;
      ratio_slot[0].rem     = sat ? '0 : DW'(n_sel);
      ratio_slot[0].div     = DW'(m_sel);
      ratio_slot[0].dvd     = '0;
      ratio_slot[0].quo     = '0;
      ratio_slot[0].ctx     = s2_ctx_ff;
      ratio_slot[0].ctx.sat = sat;
   end

   // Output fraction row
   for (genvar j = 0; j < RATIO_STEPS; j++) begin : g_ratio
      stw_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .prev_slot (ratio_slot[j]),
         .next_slot (ratio_slot[j+1])
      );
   end

   // Output register
   always_comb begin
      rsp_beat_in.period_error = ratio_slot[RATIO_STEPS].ctx.period_error;
      if (ratio_slot[RATIO_STEPS].ctx.period_error) begin
         rsp_beat_in.wave_value = '0;
      end else if (ratio_slot[RATIO_STEPS].ctx.sat) begin
         rsp_beat_in.wave_value = WAVE_ONE;
      end else begin
         rsp_beat_in.wave_value = {1'b0, ratio_slot[RATIO_STEPS].quo};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ratio_slot[RATIO_STEPS].valid;
         rsp_beat_ff  <= rsp_beat_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

endmodule

// ----- hdl/stw_div_cell.sv -----
module stw_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  stw_pkg::div_slot_type prev_slot,
   output stw_pkg::div_slot_type next_slot
);
   import stw_pkg::*;

   div_slot_type slot_ff;
   div_slot_type slot_in;
   logic [DW:0]  trial;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial   = {prev_slot.rem, prev_slot.dvd[DW-1]};
      slot_in = prev_slot;
      slot_in.dvd = prev_slot.dvd << 1;
      if (trial >= {1'b0, prev_slot.div}) begin
         slot_in.rem = DW'(trial - {1'b0, prev_slot.div});
         slot_in.quo = {prev_slot.quo[OUT_BITS-2:0], 1'b1};
      end else begin
         slot_in.rem = trial[DW-1:0];
         slot_in.quo = {prev_slot.quo[OUT_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else if (en) begin
         slot_ff <= slot_in;
      end
   end

   assign next_slot = slot_ff;

endmodule

// ----- hdl/stw_checker.sv -----
module stw_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input stw_pkg::rsp_beat_type rsp_beat
);
   import stw_pkg::*;

   // Held result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_beat))
      else $error("result beat changed while stalled");

   // Pipeline takes input exactly when the output side can move
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output stall");

   // Zero period forces a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beat.period_error |-> rsp_beat.wave_value == '0)
      else $error("period error with nonzero value");

   // Value never exceeds one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_beat.wave_value <= WAVE_ONE)
      else $error("wave value above one");

endmodule

bind skewed_triangle_wave_core stw_checker u_stw_checker (.*);
